// File: hdl/cone_level_set_point_query_unit_defines.svh
// Assertion macros for the capped cone point query unit.
// Included by the RTL files that carry assertions; needs clk_i and rst_ni in scope.
`ifndef CONE_LEVEL_SET_POINT_QUERY_UNIT_DEFINES_SVH
`define CONE_LEVEL_SET_POINT_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CLSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CLSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/clsq_pkg.sv
// Package for the capped cone point query unit: constants, item and cell types, helpers.
// Used by the square root cell, the divider cell and the top level; depends on nothing.
`default_nettype none

package clsq_pkg;

  localparam int CoordW    = 32;
  localparam int CoordFrac = 16;
  localparam int NormW     = 16;
  localparam int NormFrac  = 14;
  localparam int CfgIdxW   = 3;

  localparam int ProdW     = 2 * CoordW;
  localparam int DiffW     = CoordW + 1;
  localparam int DqW       = 2 * DiffW - CoordFrac;
  localparam int WideW     = 3 * CoordW;
  localparam int ClampBit  = 60;
  localparam int LzW       = $clog2(CoordW + 1);
  localparam int ShW       = $clog2(CoordW);
  localparam int SqrtCells = ProdW / 2;
  localparam int DivCells  = NormFrac + 1;
  localparam int DivW      = CoordW + NormFrac;

  localparam logic signed [ProdW-1:0] SatMax = (ProdW'(1) <<< (CoordW - 1)) - ProdW'(1);
  localparam logic signed [ProdW-1:0] SatMin = -(ProdW'(1) <<< (CoordW - 1));
  localparam logic [ProdW-1:0] TermClamp = ProdW'(1) << ClampBit;
  localparam logic signed [NormW-1:0] NormOne = NormW'(1) <<< NormFrac;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvA  = 3'd0,
    CfgApex  = 3'd1,
    CfgShift = 3'd2,
    CfgLoCap = 3'd3,
    CfgHiCap = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RegInside  = 2'd0,
    RegOutside = 2'd1,
    RegSurface = 2'd2,
    RegCap     = 2'd3
  } region_e;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
  } query_t;

  typedef struct packed {
    region_e                  region;
    logic                     in_range;
    logic signed [CoordW-1:0] level_value;
    logic signed [CoordW-1:0] grad_x;
    logic signed [CoordW-1:0] grad_y;
    logic signed [CoordW-1:0] grad_z;
    logic signed [NormW-1:0]  norm_x;
    logic signed [NormW-1:0]  norm_y;
    logic signed [NormW-1:0]  norm_z;
    logic                     degenerate;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    region_e                 region;
    logic                    in_range;
    logic                    on_cap;
    logic                    cap_lo;
    logic [CoordW-1:0]       level;
    logic [2:0][CoordW-1:0]  g;
    logic                    degen;
    logic                    sat;
  } side_t;

  typedef struct packed {
    logic [ProdW-1:0]       v;
    logic [ProdW-1:0]       r;
    logic [ProdW-1:0]       bitw;
    logic [2:0][CoordW-1:0] m;
    side_t                  side;
  } sq_t;

  typedef struct packed {
    logic [2:0][DivW-1:0]     rem;
    logic [2:0][DivCells-1:0] q;
    logic [DivW-1:0]          dsh;
    side_t                    side;
  } dv_t;

  typedef struct packed {
    logic              clip;
    logic [CoordW-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ProdW-1:0] v);
    sat_t s;
    s.clip = 1'b0;
    s.val  = v[CoordW-1:0];
    if (v > SatMax) begin
      s.clip = 1'b1;
      s.val  = SatMax[CoordW-1:0];
    end else if (v < SatMin) begin
      s.clip = 1'b1;
      s.val  = SatMin[CoordW-1:0];
    end
    return s;
  endfunction

  function automatic logic [LzW-1:0] lead_zeros(input logic [CoordW-1:0] v);
    logic [LzW-1:0] n;
    n = LzW'(CoordW);
    for (int i = 0; i < CoordW; i++) begin
      if (v[i]) begin
        n = LzW'(CoordW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hdl/clsq_sqrt_cell.sv
// One digit cell of the integer square root chain: one result bit per cell.
// Depends on clsq_pkg for the cell data type.
`default_nettype none

module clsq_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  clsq_pkg::sq_t data_i,
  output logic          valid_o,
  output clsq_pkg::sq_t data_o
);

  logic          valid_q;
  clsq_pkg::sq_t data_d, data_q;
  logic [clsq_pkg::ProdW-1:0] trial;

  always_comb begin
    data_d      = data_i;
    trial       = data_i.r + data_i.bitw;
    data_d.bitw = data_i.bitw >> 2;
    if (data_i.v >= trial) begin
      data_d.v = data_i.v - trial;
      data_d.r = (data_i.r >> 1) + data_i.bitw;
    end else begin
      data_d.r = data_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/clsq_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for each of three lanes.
// Depends on clsq_pkg for the cell data type.
`default_nettype none

module clsq_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  clsq_pkg::dv_t data_i,
  output logic          valid_o,
  output clsq_pkg::dv_t data_o
);

  logic          valid_q;
  clsq_pkg::dv_t data_d, data_q;

  always_comb begin
    data_d     = data_i;
    data_d.dsh = data_i.dsh >> 1;
    for (int i = 0; i < 3; i++) begin
      if (data_i.rem[i] >= data_i.dsh) begin
        data_d.rem[i] = data_i.rem[i] - data_i.dsh;
        data_d.q[i]   = {data_i.q[i][clsq_pkg::DivCells-2:0], 1'b1};
      end else begin
        data_d.q[i]   = {data_i.q[i][clsq_pkg::DivCells-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/cone_level_set_point_query_unit.sv
// Capped cone point query unit. A new item can start every cycle; busy stays low.
// Each result appears with done_o once its accepted item has passed through
// 9 arithmetic stages, 32 square root cells, 15 divider cells and an output register.
// Throughput is one item per cycle; the receiver cannot stall, so nothing backs up.
// Reset clears the pipeline valid bits and loads the register defaults.
// Depends on clsq_pkg, clsq_sqrt_cell, clsq_div_cell and the defines header.
`default_nettype none
`include "cone_level_set_point_query_unit_defines.svh"

module cone_level_set_point_query_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  clsq_pkg::query_t                  query_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [clsq_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [clsq_pkg::CoordW-1:0]       cfg_data_i,
  output logic                              done_o,
  output clsq_pkg::result_t                 result_o
);

  localparam int W  = clsq_pkg::CoordW;
  localparam int PW = clsq_pkg::ProdW;

  logic [W-1:0]        inv_q;
  logic signed [W-1:0] b_q, c_q, lo_q, hi_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;

  clsq_pkg::query_t x1_q;

  logic [PW-1:0]                  xx_d, yy_d, xx_q, yy_q;
  logic [2*clsq_pkg::DiffW-1:0]   dd_d, dd_q;
  logic signed [PW-1:0]           xinv_d, yinv_d, xinv_q, yinv_q;
  logic signed [clsq_pkg::DiffW-1:0] d2_d, d2_q;
  logic [W-1:0]                   ax, ay;
  logic [clsq_pkg::DiffW-1:0]     ad;
  clsq_pkg::side_t                side2_d, side2_q;

  logic [PW-1:0]                  s3_d, s3_q;
  logic [clsq_pkg::DqW-1:0]       dq3_q, dq4_q, dq5_q;
  logic signed [PW-1:0]           gz_full;
  clsq_pkg::sat_t                 sx, sy, sz;
  clsq_pkg::side_t                side3_d, side3_q;

  logic [PW-1:0]                  pl_q, ph_q;
  logic [2:0][W-1:0]              m4_d, m4_q, m5_q;
  clsq_pkg::side_t                side4_d, side4_q, side5_q;

  logic [clsq_pkg::WideW-1:0]     full5;
  logic [PW-1:0]                  t5, term5_d, term5_q;
  logic [W-1:0]                   mx5_d, mx5_q;

  logic signed [PW-1:0]           lv6_d, lv6_q;
  logic [clsq_pkg::LzW-1:0]       lz6;
  logic [clsq_pkg::ShW-1:0]       sh6_d, sh6_q;
  logic [2:0][W-1:0]              m6_q;
  clsq_pkg::side_t                side6_q;

  clsq_pkg::sat_t                 lsat;
  logic [2:0][W-1:0]              m7_d, m7_q, m8_q, m9_q;
  clsq_pkg::side_t                side7_d, side7_q, side8_q, side9_q;
  logic [2:0][PW-1:0]             sq8_d, sq8_q;
  logic [PW-1:0]                  sum9_q;

  logic            sqv_w [clsq_pkg::SqrtCells+1];
  clsq_pkg::sq_t   sq_w  [clsq_pkg::SqrtCells+1];
  logic            dvv_w [clsq_pkg::DivCells+1];
  clsq_pkg::dv_t   dv_w  [clsq_pkg::DivCells+1];

  clsq_pkg::dv_t     dv_end;
  clsq_pkg::result_t res_d, res_q;
  logic              done_q;
  logic signed [clsq_pkg::NormW-1:0] nq [3];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= W'(1) << clsq_pkg::CoordFrac;
      b_q   <= '0;
      c_q   <= '0;
      lo_q  <= -(W'(1) <<< clsq_pkg::CoordFrac);
      hi_q  <= W'(1) <<< clsq_pkg::CoordFrac;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        clsq_pkg::CfgInvA:  inv_q <= cfg_data_i;
        clsq_pkg::CfgApex:  b_q   <= cfg_data_i;
        clsq_pkg::CfgShift: c_q   <= cfg_data_i;
        clsq_pkg::CfgLoCap: lo_q  <= cfg_data_i;
        clsq_pkg::CfgHiCap: hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ax     = x1_q.px[W-1] ? W'(-x1_q.px) : x1_q.px;
    ay     = x1_q.py[W-1] ? W'(-x1_q.py) : x1_q.py;
    d2_d   = clsq_pkg::DiffW'(x1_q.pz) - clsq_pkg::DiffW'(b_q);
    ad     = d2_d[clsq_pkg::DiffW-1] ? clsq_pkg::DiffW'(-d2_d) : d2_d;
    xx_d   = {{W{1'b0}}, ax} * {{W{1'b0}}, ax};
    yy_d   = {{W{1'b0}}, ay} * {{W{1'b0}}, ay};
    dd_d   = {{clsq_pkg::DiffW{1'b0}}, ad} * {{clsq_pkg::DiffW{1'b0}}, ad};
    xinv_d = PW'(x1_q.px) * $signed({{W{1'b0}}, inv_q});
    yinv_d = PW'(x1_q.py) * $signed({{W{1'b0}}, inv_q});
    side2_d          = '0;
    side2_d.in_range = (x1_q.pz > lo_q) && (x1_q.pz < hi_q);
    side2_d.cap_lo   = (x1_q.pz == lo_q);
    side2_d.on_cap   = (x1_q.pz == lo_q) || (x1_q.pz == hi_q);
  end

  always_comb begin
    s3_d    = xx_q + yy_q;
    gz_full = -(PW'(d2_q) <<< 1);
    sx      = clsq_pkg::sat32(xinv_q >>> (clsq_pkg::CoordFrac - 1));
    sy      = clsq_pkg::sat32(yinv_q >>> (clsq_pkg::CoordFrac - 1));
    sz      = clsq_pkg::sat32(gz_full);
    side3_d      = side2_q;
    side3_d.g[0] = sx.val;
    side3_d.g[1] = sy.val;
    side3_d.g[2] = sz.val;
    side3_d.sat  = sx.clip || sy.clip || sz.clip;
  end

  always_comb begin
    side4_d = side3_q;
    for (int i = 0; i < 3; i++) begin
      m4_d[i] = side3_q.g[i][W-1] ? (W'(0) - side3_q.g[i]) : side3_q.g[i];
    end
    side4_d.degen = (side3_q.g[0] == '0) && (side3_q.g[1] == '0) && (side3_q.g[2] == '0);
  end

  always_comb begin
    full5   = {{W{1'b0}}, pl_q} + {ph_q, {W{1'b0}}};
    t5      = full5[clsq_pkg::WideW-1:W];
    term5_d = (t5 > clsq_pkg::TermClamp) ? clsq_pkg::TermClamp : t5;
    mx5_d   = m4_q[0];
    if (m4_q[1] > mx5_d) begin
      mx5_d = m4_q[1];
    end
    if (m4_q[2] > mx5_d) begin
      mx5_d = m4_q[2];
    end
  end

  always_comb begin
    lv6_d = $signed(term5_q) - $signed(PW'(dq5_q)) - PW'(c_q);
    lz6   = clsq_pkg::lead_zeros(mx5_q);
    sh6_d = (lz6 == '0) ? '0 : clsq_pkg::ShW'(lz6 - clsq_pkg::LzW'(1));
  end

  always_comb begin
    lsat          = clsq_pkg::sat32(lv6_q);
    side7_d       = side6_q;
    side7_d.level = lsat.val;
    side7_d.sat   = side6_q.sat || lsat.clip;
    if (side6_q.in_range) begin
      if (lv6_q < 0) begin
        side7_d.region = clsq_pkg::RegInside;
      end else if (lv6_q == 0) begin
        side7_d.region = clsq_pkg::RegSurface;
      end else begin
        side7_d.region = clsq_pkg::RegOutside;
      end
    end else if (side6_q.on_cap) begin
      side7_d.region = clsq_pkg::RegCap;
    end else begin
      side7_d.region = clsq_pkg::RegOutside;
    end
    for (int i = 0; i < 3; i++) begin
      m7_d[i] = m6_q[i] << sh6_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq8_d[i] = {{W{1'b0}}, m7_q[i]} * {{W{1'b0}}, m7_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= query_i;
    xx_q    <= xx_d;
    yy_q    <= yy_d;
    dd_q    <= dd_d;
    xinv_q  <= xinv_d;
    yinv_q  <= yinv_d;
    d2_q    <= d2_d;
    side2_q <= side2_d;
    s3_q    <= s3_d;
    dq3_q   <= dd_q[2*clsq_pkg::DiffW-1:clsq_pkg::CoordFrac];
    side3_q <= side3_d;
    pl_q    <= {{W{1'b0}}, s3_q[W-1:0]} * {{W{1'b0}}, inv_q};
    ph_q    <= {{W{1'b0}}, s3_q[PW-1:W]} * {{W{1'b0}}, inv_q};
    dq4_q   <= dq3_q;
    m4_q    <= m4_d;
    side4_q <= side4_d;
    term5_q <= term5_d;
    mx5_q   <= mx5_d;
    dq5_q   <= dq4_q;
    m5_q    <= m4_q;
    side5_q <= side4_q;
    lv6_q   <= lv6_d;
    sh6_q   <= sh6_d;
    m6_q    <= m5_q;
    side6_q <= side5_q;
    m7_q    <= m7_d;
    side7_q <= side7_d;
    sq8_q   <= sq8_d;
    m8_q    <= m7_q;
    side8_q <= side7_q;
    sum9_q  <= sq8_q[0] + sq8_q[1] + sq8_q[2];
    m9_q    <= m8_q;
    side9_q <= side8_q;
  end

  always_comb begin
    sqv_w[0]      = v9_q;
    sq_w[0].v     = sum9_q;
    sq_w[0].r     = '0;
    sq_w[0].bitw  = PW'(1) << (PW - 2);
    sq_w[0].m     = m9_q;
    sq_w[0].side  = side9_q;
  end

  for (genvar k = 0; k < clsq_pkg::SqrtCells; k++) begin : g_sqrt
    clsq_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sqv_w[k]),
      .data_i  (sq_w[k]),
      .valid_o (sqv_w[k+1]),
      .data_o  (sq_w[k+1])
    );
  end

  always_comb begin
    dvv_w[0]      = sqv_w[clsq_pkg::SqrtCells];
    dv_w[0].side  = sq_w[clsq_pkg::SqrtCells].side;
    dv_w[0].dsh   = {sq_w[clsq_pkg::SqrtCells].r[W-1:0], {clsq_pkg::NormFrac{1'b0}}};
    for (int i = 0; i < 3; i++) begin
      dv_w[0].rem[i] = {sq_w[clsq_pkg::SqrtCells].m[i], {clsq_pkg::NormFrac{1'b0}}};
      dv_w[0].q[i]   = '0;
    end
  end

  for (genvar k = 0; k < clsq_pkg::DivCells; k++) begin : g_div
    clsq_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dvv_w[k]),
      .data_i  (dv_w[k]),
      .valid_o (dvv_w[k+1]),
      .data_o  (dv_w[k+1])
    );
  end

  always_comb begin
    dv_end = dv_w[clsq_pkg::DivCells];
    for (int i = 0; i < 3; i++) begin
      nq[i] = dv_end.side.g[i][W-1] ? -$signed(clsq_pkg::NormW'(dv_end.q[i]))
                                    : $signed(clsq_pkg::NormW'(dv_end.q[i]));
      if (dv_end.side.degen) begin
        nq[i] = '0;
      end
    end
    res_d        = '0;
    res_d.region = dv_end.side.region;
    if (dv_end.side.in_range) begin
      res_d.in_range    = 1'b1;
      res_d.level_value = dv_end.side.level;
      res_d.grad_x      = dv_end.side.g[0];
      res_d.grad_y      = dv_end.side.g[1];
      res_d.grad_z      = dv_end.side.g[2];
      res_d.norm_x      = nq[0];
      res_d.norm_y      = nq[1];
      res_d.norm_z      = nq[2];
      res_d.degenerate  = dv_end.side.degen;
      res_d.saturated   = dv_end.side.sat;
    end else if (dv_end.side.region == clsq_pkg::RegCap) begin
      res_d.norm_z = dv_end.side.cap_lo ? -clsq_pkg::NormOne : clsq_pkg::NormOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvv_w[clsq_pkg::DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `CLSQ_ASSERT_NXT(a_accept_enters, start && !busy, v1_q, "Accepted item did not enter the pipeline.")
  `CLSQ_ASSERT_IMP(a_out_of_range_zero, done_o && !result_o.in_range,
    result_o.level_value == '0 && result_o.grad_z == '0 && !result_o.degenerate &&
    !result_o.saturated, "Out-of-range item carries nonzero value fields.")
  `CLSQ_ASSERT_IMP(a_degen_zero_normal, done_o && result_o.degenerate,
    result_o.norm_x == '0 && result_o.norm_y == '0 && result_o.norm_z == '0,
    "Zero gradient item has a nonzero normal.")
  `CLSQ_ASSERT_IMP(a_cap_not_in_range, done_o && result_o.region == clsq_pkg::RegCap,
    !result_o.in_range, "Cap plane item is flagged in range.")

endmodule

`default_nettype wire

// File: test/cone_level_set_point_query_unit_checker.sv
// Checker for the capped cone point query unit: tracks the register file,
// predicts each result from the accepted query and compares it at done_o.
// Depends on clsq_pkg.
`timescale 1ns / 100ps

module cone_level_set_point_query_unit_checker
  import clsq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  query_t            query_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0] cfg_data_i,
  input  logic              done_o,
  input  result_t           result_o,
  output int                fail_count,
  output int                pending_count
);

  logic [31:0] inv_a2, apex, shift, lo_cap, hi_cap;
  result_t pending_q[$];

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v,
                                                inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] grad_planar(input logic signed [63:0] c,
                                                     input logic signed [63:0] inv);
    logic signed [63:0] p;
    logic [63:0] m;
    p = c * inv;
    if (p >= 0) return p >>> (CoordFrac - 1);
    m = -p;
    m = (m + ((64'd1 << (CoordFrac - 1)) - 64'd1)) >> (CoordFrac - 1);
    return -$signed(m);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic result_t cone_query(input query_t q);
    result_t e;
    logic signed [63:0] x, y, z, lo, hi, d, lv, g[3];
    logic [63:0] s, dq, mg[3], mx, sum, r, qt;
    logic [127:0] prod, term;
    logic sat;
    e = '0;
    x = 64'(q.px); y = 64'(q.py); z = 64'(q.pz);
    lo = 64'($signed(lo_cap)); hi = 64'($signed(hi_cap));
    sat = 1'b0;
    if (z > lo && z < hi) begin
      d = z - 64'($signed(apex));
      s = mag64(x) * mag64(x) + mag64(y) * mag64(y);
      dq = (mag64(d) * mag64(d)) >> CoordFrac;
      prod = {64'd0, s} * {96'd0, inv_a2};
      term = prod >> (2 * CoordFrac);
      if (term > (128'd1 << 60)) term = 128'd1 << 60;
      lv = $signed(term[63:0]) - $signed(dq) - 64'($signed(shift));
      g[0] = clip32(grad_planar(x, {32'd0, inv_a2}), sat);
      g[1] = clip32(grad_planar(y, {32'd0, inv_a2}), sat);
      g[2] = clip32(-64'sd2 * d, sat);
      e.region = lv < 0 ? RegInside : (lv == 0 ? RegSurface : RegOutside);
      e.in_range = 1'b1;
      e.level_value = 32'(clip32(lv, sat));
      e.grad_x = 32'(g[0]); e.grad_y = 32'(g[1]); e.grad_z = 32'(g[2]);
      e.degenerate = g[0] == 0 && g[1] == 0 && g[2] == 0;
      if (!e.degenerate) begin
        for (int i = 0; i < 3; i++) mg[i] = mag64(g[i]);
        mx = mg[0];
        if (mg[1] > mx) mx = mg[1];
        if (mg[2] > mx) mx = mg[2];
        while (mx < (64'd1 << 30)) begin
          mx <<= 1;
          for (int i = 0; i < 3; i++) mg[i] <<= 1;
        end
        sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        r = root64(sum);
        qt = (mg[0] << NormFrac) / r; e.norm_x = 16'(g[0] < 0 ? -qt : qt);
        qt = (mg[1] << NormFrac) / r; e.norm_y = 16'(g[1] < 0 ? -qt : qt);
        qt = (mg[2] << NormFrac) / r; e.norm_z = 16'(g[2] < 0 ? -qt : qt);
      end
      e.saturated = sat;
    end else if (z == lo || z == hi) begin
      e.region = RegCap;
      e.norm_z = z == lo ? -NormOne : NormOne;
    end else begin
      e.region = RegOutside;
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = pending_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      inv_a2 <= 32'h0001_0000;
      apex <= '0;
      shift <= '0;
      lo_cap <= 32'hFFFF_0000;
      hi_cap <= 32'h0001_0000;
      pending_q.delete();
      fail_count = 0;
    end else begin
      if (start && !busy) pending_q.insert(pending_q.size(), cone_query(query_i));
      if (done_o) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected item", 64'(result_o.level_value), '0);
        end else begin
          e = pending_q.pop_front();
          if (result_o.region !== e.region)
            report_mismatch("region", 64'(result_o.region), 64'(e.region));
          if (result_o.in_range !== e.in_range)
            report_mismatch("in_range", 64'(result_o.in_range), 64'(e.in_range));
          if (result_o.level_value !== e.level_value)
            report_mismatch("level_value", 64'(result_o.level_value), 64'(e.level_value));
          if (result_o.grad_x !== e.grad_x)
            report_mismatch("grad_x", 64'(result_o.grad_x), 64'(e.grad_x));
          if (result_o.grad_y !== e.grad_y)
            report_mismatch("grad_y", 64'(result_o.grad_y), 64'(e.grad_y));
          if (result_o.grad_z !== e.grad_z)
            report_mismatch("grad_z", 64'(result_o.grad_z), 64'(e.grad_z));
          if (result_o.norm_x !== e.norm_x)
            report_mismatch("norm_x", 64'(result_o.norm_x), 64'(e.norm_x));
          if (result_o.norm_y !== e.norm_y)
            report_mismatch("norm_y", 64'(result_o.norm_y), 64'(e.norm_y));
          if (result_o.norm_z !== e.norm_z)
            report_mismatch("norm_z", 64'(result_o.norm_z), 64'(e.norm_z));
          if (result_o.degenerate !== e.degenerate)
            report_mismatch("degenerate", 64'(result_o.degenerate), 64'(e.degenerate));
          if (result_o.saturated !== e.saturated)
            report_mismatch("saturated", 64'(result_o.saturated), 64'(e.saturated));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgInvA: inv_a2 <= cfg_data_i;
          CfgApex: apex <= cfg_data_i;
          CfgShift: shift <= cfg_data_i;
          CfgLoCap: lo_cap <= cfg_data_i;
          CfgHiCap: hi_cap <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: test/cone_level_set_point_query_unit_tb.sv
// Testbench top for the capped cone point query unit: drives register settings
// and query items with random gaps; the checker module judges the results.
// Depends on clsq_pkg, the unit and cone_level_set_point_query_unit_checker.
`timescale 1ns / 100ps

module cone_level_set_point_query_unit_tb;
  import clsq_pkg::*;

  localparam int Latency = 57;
  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [CfgIdxW-1:0] UnusedIdx = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  query_t query_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic done_o;
  result_t result_o;
  int fail_count, pending_count;
  logic [31:0] cur_lo, cur_hi;

  always #1 clk_i = ~clk_i;

  cone_level_set_point_query_unit dut (.*);

  cone_level_set_point_query_unit_checker checker_i (.*);

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 7 ? $urandom_range(1, 2) : $urandom_range(3, 30);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgLoCap) cur_lo = val;
    if (idx == CfgHiCap) cur_hi = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic send(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                      input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      idle_gap();
    end
    start <= 1'b1;
    query_i <= {x, y, z};
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      3: return 32'($signed($urandom_range(0, 512)) - 256);
      4: return '0;
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  function automatic logic [31:0] z_coord();
    int unsigned span;
    case ($urandom_range(0, 9))
      0: return cur_lo;
      1: return cur_hi;
      2: return $urandom;
      default: begin
        span = cur_hi - cur_lo;
        if ($signed(cur_hi) <= $signed(cur_lo) || span < 2) return $urandom;
        return cur_lo + 1 + ($urandom % (span - 1));
      end
    endcase
  endfunction

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      send(coord(), coord(), z_coord(), i % 40 > 25);
    end
    start <= 1'b0;
  endtask

  initial begin
    cur_lo = 32'hFFFF_0000;
    cur_hi = One;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send('0, '0, '0, 0);
    send('0, '0, 32'hFFFF_0000, 0);
    send('0, '0, One, 0);
    send('0, '0, 32'h0002_0000, 0);
    send('0, '0, 32'h8000_0000, 0);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 0);
    send(32'h8000_0000, 32'h8000_0000, 32'hFFFF_8001, 0);
    send(One, '0, '0, 0);
    send(32'h0000_B505, 32'h0000_B505, '0, 1);
    send(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1);
    send(32'h0000_4000, '0, 32'h0000_4000, 1);
    start <= 1'b0;
    drain();

    write_reg(CfgInvA, 32'hFFFF_FFFF);
    write_reg(CfgApex, 32'h8000_0000);
    write_reg(CfgShift, 32'h7FFF_FFFF);
    write_reg(CfgLoCap, 32'h8000_0000);
    write_reg(CfgHiCap, 32'h7FFF_FFFF);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 0);
    send('0, '0, 32'h8000_0001, 0);
    send(32'h8000_0000, '0, '0, 0);
    random_items(100);
    drain();

    write_reg(CfgInvA, '0);
    write_reg(CfgApex, '0);
    write_reg(CfgShift, 32'h8000_0000);
    write_reg(CfgLoCap, 32'h0000_0005);
    write_reg(CfgHiCap, 32'h0000_0005);
    send('0, '0, 32'h0000_0005, 0);
    send(One, One, 32'h0000_0004, 0);
    start <= 1'b0;
    drain();
    write_reg(CfgLoCap, 32'hFFF0_0000);
    write_reg(CfgHiCap, 32'h0010_0000);
    send('0, '0, '0, 0);
    random_items(100);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgInvA, ph == 0 ? 32'h0000_0001 : $urandom_range(1, 4 << 16));
      write_reg(CfgApex, 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)));
      write_reg(CfgShift, ph == 3 ? $urandom : 32'($signed($urandom_range(0, 2 << 16)) - One));
      write_reg(CfgLoCap, 32'(-$signed($urandom_range(0, 8 << 16))));
      write_reg(CfgHiCap, $urandom_range(1, 8 << 16));
      cfg_valid_i <= 1'b1;
      cfg_index_i <= UnusedIdx;
      cfg_data_i <= $urandom;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      random_items(90);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/clsq_pkg.sv
hdl/clsq_sqrt_cell.sv
hdl/clsq_div_cell.sv
hdl/cone_level_set_point_query_unit.sv
test/cone_level_set_point_query_unit_checker.sv
test/cone_level_set_point_query_unit_tb.sv
